// ===== hdl/dmma_pkg.sv =====
// Shared types, codes and arithmetic helpers for the matrix multiply-accumulate block.
`timescale 1ns / 1ps
`default_nettype none
package dmma_pkg;

  localparam int unsigned MAX_DIM = 64;
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W  = 2 * IDX_W;
  localparam int unsigned SIZE_W  = 7;

  localparam logic [2:0] OP_LOAD_A  = 3'd0;
  localparam logic [2:0] OP_LOAD_B  = 3'd1;
  localparam logic [2:0] OP_LOAD_C  = 3'd2;
  localparam logic [2:0] OP_COMPUTE = 3'd3;
  localparam logic [2:0] OP_READ_C  = 3'd4;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]         operation;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [31:0] factor_value;
    logic signed [63:0] initial_sum;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [63:0] data_value;
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_col;
    logic               saturation_seen;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             load_c;
    logic             host_rd;
    logic             c_rd;
    logic             ab_rd;
    logic             c_wb;
    logic             clear_sat;
    logic             done;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // Last index in use: size zero counts as one, sizes above the grid are clamped
  function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size);
    logic [IDX_W-1:0] r;
    if (size == '0) r = '0;
    else if (32'(size) > MAX_DIM) r = IDX_W'(MAX_DIM - 1);
    else r = IDX_W'(size - 7'd1);
    return r;
  endfunction

  // Signed saturating 64-bit add
  function automatic logic [64:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    logic        ovf;
    s   = x + y;
    ovf = (x[63] == y[63]) && (s[63] != x[63]);
    if (ovf) s = x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return {ovf, s};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dmma_ctrl.sv =====
// Controller: item decode, configuration register and the i/j/k compute sequencer.
`timescale 1ns / 1ps
`default_nettype none
module dmma_ctrl import dmma_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [2:0]        op_i,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  output logic                   busy_o,
  output cmd_t                   cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOAD = 3'd1;
  localparam logic [2:0] S_KLOOP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic              drain_q, drain_d;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  last;
  logic              take;

  assign last   = last_index(size_q);
  assign busy_o = (state_q != S_IDLE);
  assign take   = start_i && !busy_o;

  // Hold the matrix size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SIZE_RESET;
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  // Sequence state and loop counters
  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    drain_d = drain_q;
    cmd_o = '0;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    cmd_o.k = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (op_i)
            OP_LOAD_A:  cmd_o.load_a = 1'b1;
            OP_LOAD_B:  cmd_o.load_b = 1'b1;
            OP_LOAD_C:  cmd_o.load_c = 1'b1;
            OP_READ_C:  cmd_o.host_rd = 1'b1;
            OP_COMPUTE: begin
              cmd_o.clear_sat = 1'b1;
              i_d = '0;
              j_d = '0;
              state_d = S_CLOAD;
            end
            default: ;
          endcase
        end
      end
      S_CLOAD: begin
        cmd_o.c_rd = 1'b1;
        k_d = '0;
        state_d = S_KLOOP;
      end
      S_KLOOP: begin
        cmd_o.ab_rd = 1'b1;
        if (k_q == last) begin
          drain_d = 1'b0;
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // wait for the read and multiply stages to empty
        if (drain_q) state_d = S_WRITE;
        else drain_d = 1'b1;
      end
      S_WRITE: begin
        cmd_o.c_wb = 1'b1;
        state_d = S_CLOAD;
        if (j_q == last) begin
          j_d = '0;
          if (i_q == last) begin
            cmd_o.done = 1'b1;
            state_d = S_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      drain_q <= drain_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dmma_datapath.sv =====
// Datapath: A, B and C memories, multiplier, saturating accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none
module dmma_datapath import dmma_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_t     cmd_i,
  input  wire in_item_t item_i,
  output logic          done_o,
  output out_item_t     result_o
);

  localparam int unsigned CELLS = MAX_DIM * MAX_DIM;

  logic [31:0] a_mem [CELLS];
  logic [31:0] b_mem [CELLS];
  logic [63:0] c_mem [CELLS];

  logic [31:0]        a_q, b_q;
  logic [63:0]        c_q;
  logic signed [63:0] prod_q;
  logic [63:0]        acc_q;
  logic               sat_q;
  logic               ab_v_q, c_v_q, prod_v_q, host_v_q, done_v_q;
  logic [IDX_W-1:0]   row_q, col_q;
  logic [ADDR_W-1:0]  host_addr;
  logic [64:0]        sum;

  assign host_addr = {item_i.row, item_i.col};
  assign sum       = sat_add(acc_q, prod_q);

  // A and B stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) a_mem[host_addr] <= item_i.factor_value;
    if (cmd_i.ab_rd) a_q <= a_mem[{cmd_i.i, cmd_i.k}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_b) b_mem[host_addr] <= item_i.factor_value;
    if (cmd_i.ab_rd) b_q <= b_mem[{cmd_i.k, cmd_i.j}];
  end

  // C store: host loads and reads, compute fetch and write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_c) c_mem[host_addr] <= item_i.initial_sum;
    else if (cmd_i.c_wb) c_mem[{cmd_i.i, cmd_i.j}] <= acc_q;
    if (cmd_i.host_rd) c_q <= c_mem[host_addr];
    else if (cmd_i.c_rd) c_q <= c_mem[{cmd_i.i, cmd_i.j}];
  end

  // Multiply, then accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_q) * $signed(b_q);
    if (c_v_q) acc_q <= c_q;
    else if (prod_v_q) acc_q <= sum[63:0];
    if (cmd_i.host_rd) begin
      row_q <= item_i.row;
      col_q <= item_i.col;
    end
  end

  // Stage valids and sticky saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_v_q <= 1'b0;
      c_v_q <= 1'b0;
      prod_v_q <= 1'b0;
      host_v_q <= 1'b0;
      done_v_q <= 1'b0;
      sat_q <= 1'b0;
    end else begin
      ab_v_q <= cmd_i.ab_rd;
      c_v_q <= cmd_i.c_rd;
      prod_v_q <= ab_v_q;
      host_v_q <= cmd_i.host_rd;
      done_v_q <= cmd_i.done;
      if (cmd_i.clear_sat) sat_q <= 1'b0;
      else if (prod_v_q && !c_v_q && sum[64]) sat_q <= 1'b1;
    end
  end

  // Present one result transfer
  assign done_o = host_v_q || done_v_q;
  always_comb begin
    result_o.result_kind     = done_v_q ? KIND_DONE : KIND_READ;
    result_o.data_value      = done_v_q ? '0 : c_q;
    result_o.out_row         = done_v_q ? '0 : row_q;
    result_o.out_col         = done_v_q ? '0 : col_q;
    result_o.saturation_seen = sat_q;
  end

endmodule
`default_nettype wire

// ===== hdl/dense_matrix_multiply_accumulate.sv =====
// Top level of the dense matrix multiply-accumulate block.
//
//  channel   signals                      transfer
//  item      start_i, busy_o, item_i      start_i high while busy_o low
//  result    done_o, result_o             done_o high, one cycle, no stall
//  config    cfg_we_i, cfg_wdata_i        cfg_we_i high
//
// Loads are written as they are taken; a read gives its result on the next cycle and
// items may follow every cycle while busy_o is low. A compute keeps busy_o high
// and uses one multiplier; the done result shows the cycle busy_o drops.
// Reset clears control and the saturation flag; the memories are not cleared.
// Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module dense_matrix_multiply_accumulate import dmma_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire in_item_t          item_i,
  output logic                   done_o,
  output out_item_t              result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i
);

  cmd_t cmd;

  dmma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (item_i.operation),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd)
  );

  dmma_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

// ===== hdl/dmma_checker.sv =====
// Port-level checker for the matrix multiply-accumulate block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module dmma_checker import dmma_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire in_item_t  item_i,
  input wire logic      done_o,
  input wire out_item_t result_o
);

  // A read transfer returns its element on the next cycle
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.operation == OP_READ_C |=>
      done_o && result_o.result_kind == KIND_READ &&
      result_o.out_row == $past(item_i.row) && result_o.out_col == $past(item_i.col))
    else $error("read result missing or misaddressed");

  // A compute transfer makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.operation == OP_COMPUTE |=> busy_o)
    else $error("compute did not raise busy");

  // The end of a compute is marked by a done result
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o && result_o.result_kind == KIND_DONE)
    else $error("compute ended without done");

  // A done result carries zero data
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.result_kind == KIND_DONE |-> result_o.data_value == '0)
    else $error("done result carries data");

endmodule

bind dense_matrix_multiply_accumulate dmma_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
